/* rtl/timestamp_history_interpolator_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the timestamp history interpolator
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef TIMESTAMP_HISTORY_INTERPOLATOR_UNIT_ASSERT_SVH
`define TIMESTAMP_HISTORY_INTERPOLATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define THI_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define THI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define THI_ASSERT(lbl, clk, rstn, prop)
`define THI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/thi_pkg.sv */
// ---------------------------------------------------------------------------
// Timestamp history interpolator package
// Shared widths, status codes and the structures passed between modules.
// ---------------------------------------------------------------------------
`default_nettype none
package thi_pkg;

  localparam int unsigned StampW  = 48;
  localparam int unsigned SampleW = 32;
  localparam int unsigned StatusW = 3;
  // Quotient width: the quotient is below the sample difference magnitude.
  localparam int unsigned QuoW    = SampleW + 1;
  localparam int unsigned ProdW   = QuoW + StampW;

  localparam logic OpInsert = 1'b0;
  localparam logic OpQuery  = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_EXACT       = 3'd0,
    ST_INTERP      = 3'd1,
    ST_BEFORE      = 3'd2,
    ST_AFTER       = 3'd3,
    ST_INSERT_DONE = 3'd4
  } status_e;

  typedef struct packed {
    logic                      is_query;
    logic [StampW-1:0]         stamp;
    logic signed [SampleW-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic signed [SampleW-1:0] value;
    status_e                   status;
    logic [StampW-1:0]         oldest_stamp;
    logic [StampW-1:0]         newest_stamp;
    logic signed [SampleW-1:0] newest_sample;
  } res_t;

endpackage
`default_nettype wire

/* rtl/timestamp_history_interpolator_unit.sv */
// An insert goes from the queue through S_INS_RD and S_INS_CAP to its result
// strobe; a query reads and compares one entry at a time (up to HISTORY_DEPTH),
// then to interpolate it runs the two-step multiply, the 33-step serial divider
// and the sign fix. The back end takes a new item only once a result is shown.
// Reset clears the ring (valid bits), the oldest slot and all control at once.
// The result strobe lasts one cycle; the receiver cannot stall it.
`default_nettype none
`include "timestamp_history_interpolator_unit_assert.svh"
module timestamp_history_interpolator_unit #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic                         opcode_i,
  input  wire logic [thi_pkg::StampW-1:0]   stamp_i,
  input  wire logic [thi_pkg::SampleW-1:0]  sample_in_i,
  output logic                              done_o,
  output logic [thi_pkg::SampleW-1:0]       result_value_o,
  output logic [thi_pkg::StatusW-1:0]       lookup_status_o,
  output logic [thi_pkg::StampW-1:0]        oldest_stamp_o,
  output logic [thi_pkg::StampW-1:0]        newest_stamp_o,
  output logic [thi_pkg::SampleW-1:0]       newest_sample_o
);
  import thi_pkg::*;

  // The front end registers one decoded item and hands it to the queue.
  logic fr_valid, q_ready, q_valid, q_pop;
  cmd_t fr_cmd, q_cmd;
  res_t res;

  thi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .opcode_i   (opcode_i),
    .stamp_i    (stamp_i),
    .sample_in_i(sample_in_i),
    .cmd_valid_o(fr_valid),
    .cmd_ready_i(q_ready),
    .cmd_o      (fr_cmd)
  );

  // The queue lets new items arrive while the back end is still dividing.
  thi_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fr_valid),
    .push_ready_o(q_ready),
    .push_data_i (fr_cmd),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_cmd)
  );

  // The back end owns the ring and performs the scan and interpolation.
  thi_back #(
    .HistoryDepth(HISTORY_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (q_cmd),
    .cmd_pop_o  (q_pop),
    .res_o      (res),
    .done_o     (done_o)
  );

  assign result_value_o  = res.value;
  assign lookup_status_o = res.status;
  assign oldest_stamp_o  = res.oldest_stamp;
  assign newest_stamp_o  = res.newest_stamp;
  assign newest_sample_o = res.newest_sample;

  // A result strobe never lasts more than one cycle.
  `THI_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  // An insert always reports a zero value.
  `THI_ASSERT(a_insert_zero, clk_i, rst_ni, !(done_o && lookup_status_o == ST_INSERT_DONE) || result_value_o == '0)
  // The back end never takes a command while a result is being shown.
  `THI_ASSERT(a_no_pop_on_done, clk_i, rst_ni, !(done_o && q_pop))

endmodule
`default_nettype wire

/* rtl/thi_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module thi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/thi_front.sv */
// ---------------------------------------------------------------------------
// Front end
// Accepts items, decodes the opcode and holds one command for the queue.
// ---------------------------------------------------------------------------
`default_nettype none
module thi_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic                         opcode_i,
  input  wire logic [thi_pkg::StampW-1:0]   stamp_i,
  input  wire logic [thi_pkg::SampleW-1:0]  sample_in_i,
  output logic                              cmd_valid_o,
  input  wire logic                         cmd_ready_i,
  output thi_pkg::cmd_t                     cmd_o
);
  import thi_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q;
  logic take;

  assign busy_o = valid_q & ~cmd_ready_i;
  assign take   = start_i & ~busy_o;

  always_comb begin
    valid_d = valid_q;
    if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q.is_query <= (opcode_i == OpQuery);
      cmd_q.stamp    <= stamp_i;
      cmd_q.sample   <= sample_in_i;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule
`default_nettype wire

/* rtl/thi_queue.sv */
// ---------------------------------------------------------------------------
// Command queue
// Two-entry queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
`default_nettype none
module thi_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  thi_pkg::cmd_t      push_data_i,
  output logic               pop_valid_o,
  input  wire logic          pop_i,
  output thi_pkg::cmd_t      pop_data_o
);
  import thi_pkg::*;

  cmd_t       slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;
  assign pop_data_o   = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/thi_back.sv */
// ---------------------------------------------------------------------------
// Back end
// Ring of samples, oldest-to-newest scan and serial interpolation divider.
// ---------------------------------------------------------------------------
`default_nettype none
module thi_back #(
  parameter int unsigned HistoryDepth = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cmd_valid_i,
  input  thi_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output thi_pkg::res_t res_o,
  output logic          done_o
);
  import thi_pkg::*;

  localparam int unsigned SlotW = $clog2(HistoryDepth);
  localparam int unsigned EntW  = StampW + SampleW;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(HistoryDepth - 1);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_INS_RD  = 10'b0000000010,
    S_INS_CAP = 10'b0000000100,
    S_RD      = 10'b0000001000,
    S_CMP     = 10'b0000010000,
    S_MUL0    = 10'b0000100000,
    S_MUL1    = 10'b0001000000,
    S_DIV     = 10'b0010000000,
    S_FIX     = 10'b0100000000,
    S_OUT     = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [SlotW-1:0]        oldest_slot_q, k_q, addr_q;
  logic [HistoryDepth-1:0] valid_q;
  logic                    rd_ok_q;
  logic [StampW-1:0]       newest_stamp_q, oldest_stamp_q;
  logic [SampleW-1:0]      newest_sample_q;
  cmd_t                    cmd_q;
  logic [StampW-1:0]       prev_stamp_q, dt_q, span_q;
  logic [SampleW-1:0]      prev_sample_q;
  logic [QuoW-1:0]         mag_q, low_q, quo_q;
  logic                    neg_q;
  logic [ProdW-1:0]        prod_q;
  logic [StampW:0]         rem_q;
  logic [5:0]              cnt_q;
  logic [SampleW-1:0]      res_value_q;
  status_e                 res_status_q;

  logic                we;
  logic [SlotW-1:0]    raddr;
  logic [EntW-1:0]     rdata;
  logic [StampW-1:0]   rd_stamp;
  logic [SampleW-1:0]  rd_sample;
  logic [SampleW:0]    dv;
  logic [56:0]         pp;
  logic [ProdW-1:0]    prod_sum;
  logic [StampW:0]     trial;
  logic [SampleW+1:0]  interp;

  function automatic logic [SlotW-1:0] wrap_inc(input logic [SlotW-1:0] s);
    wrap_inc = (s == LastSlot) ? '0 : s + 1'b1;
  endfunction

  assign we    = (state_q == S_IDLE) && cmd_valid_i && !cmd_i.is_query;
  assign raddr = (state_q == S_INS_RD) ? oldest_slot_q : addr_q;

  thi_ram #(
    .Width(EntW),
    .Depth(HistoryDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(oldest_slot_q),
    .wdata_i({cmd_i.stamp, cmd_i.sample}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Entries never written read as zero, as after reset.
  assign rd_stamp  = rd_ok_q ? rdata[EntW-1:SampleW] : '0;
  assign rd_sample = rd_ok_q ? rdata[SampleW-1:0] : '0;

  assign dv     = {rd_sample[SampleW-1], rd_sample} - {prev_sample_q[SampleW-1], prev_sample_q};
  assign pp     = 57'(mag_q) * 57'((state_q == S_MUL0) ? dt_q[23:0] : dt_q[47:24]);
  // Full product once the upper partial product is added in.
  assign prod_sum = prod_q + {pp, 24'd0};
  assign trial  = {rem_q[StampW-1:0], low_q[QuoW-1]};
  assign interp = neg_q
      ? {{2{prev_sample_q[SampleW-1]}}, prev_sample_q} - {1'b0, quo_q}
      : {{2{prev_sample_q[SampleW-1]}}, prev_sample_q} + {1'b0, quo_q};

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
  assign done_o    = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          state_d = cmd_i.is_query ? S_RD : S_INS_RD;
        end
      end
      S_INS_RD:  state_d = S_INS_CAP;
      S_INS_CAP: state_d = S_OUT;
      S_RD:      state_d = S_CMP;
      S_CMP: begin
        if (rd_stamp == cmd_q.stamp) begin
          state_d = S_OUT;
        end else if (rd_stamp > cmd_q.stamp) begin
          state_d = (k_q == '0) ? S_OUT : S_MUL0;
        end else if (k_q == LastSlot) begin
          state_d = S_OUT;
        end else begin
          state_d = S_RD;
        end
      end
      S_MUL0: state_d = S_MUL1;
      S_MUL1: state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == 6'd1) begin
          state_d = S_FIX;
        end
      end
      S_FIX:   state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      oldest_slot_q   <= '0;
      valid_q         <= '0;
      rd_ok_q         <= 1'b0;
      newest_stamp_q  <= '0;
      newest_sample_q <= '0;
      oldest_stamp_q  <= '0;
      k_q             <= '0;
      addr_q          <= '0;
      cnt_q           <= '0;
    end else begin
      state_q <= state_d;
      rd_ok_q <= valid_q[raddr];
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.is_query) begin
              addr_q <= oldest_slot_q;
              k_q    <= '0;
            end else begin
              valid_q[oldest_slot_q] <= 1'b1;
              newest_stamp_q         <= cmd_i.stamp;
              newest_sample_q        <= cmd_i.sample;
              oldest_slot_q          <= wrap_inc(oldest_slot_q);
            end
          end
        end
        S_INS_CAP: oldest_stamp_q <= rd_stamp;
        S_CMP: begin
          k_q    <= k_q + 1'b1;
          addr_q <= wrap_inc(addr_q);
        end
        S_MUL1: cnt_q <= 6'(QuoW);
        S_DIV:  cnt_q <= cnt_q - 6'd1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_q <= cmd_i;
        end
      end
      S_INS_CAP: begin
        res_value_q  <= '0;
        res_status_q <= ST_INSERT_DONE;
      end
      S_CMP: begin
        dt_q          <= cmd_q.stamp - prev_stamp_q;
        span_q        <= rd_stamp - prev_stamp_q;
        neg_q         <= dv[SampleW];
        mag_q         <= dv[SampleW] ? (~dv + 1'b1) : dv;
        // Only an entry below the target can become the earlier point.
        if (rd_stamp < cmd_q.stamp) begin
          prev_stamp_q  <= rd_stamp;
          prev_sample_q <= rd_sample;
        end
        if (rd_stamp == cmd_q.stamp) begin
          res_value_q  <= rd_sample;
          res_status_q <= ST_EXACT;
        end else if (rd_stamp > cmd_q.stamp) begin
          res_value_q  <= rd_sample;
          res_status_q <= (k_q == '0) ? ST_BEFORE : ST_INTERP;
        end else begin
          res_value_q  <= newest_sample_q;
          res_status_q <= ST_AFTER;
        end
      end
      S_MUL0: prod_q <= {24'd0, pp};
      S_MUL1: begin
        rem_q <= {1'b0, prod_sum[ProdW-1:QuoW]};
        low_q <= prod_sum[QuoW-1:0];
        quo_q <= '0;
      end
      S_DIV: begin
        low_q <= {low_q[QuoW-2:0], 1'b0};
        if (trial >= {1'b0, span_q}) begin
          rem_q <= trial - {1'b0, span_q};
          quo_q <= {quo_q[QuoW-2:0], 1'b1};
        end else begin
          rem_q <= trial;
          quo_q <= {quo_q[QuoW-2:0], 1'b0};
        end
      end
      S_FIX: res_value_q <= interp[SampleW-1:0];
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o.value         = res_value_q;
    res_o.status        = res_status_q;
    res_o.oldest_stamp  = oldest_stamp_q;
    res_o.newest_stamp  = newest_stamp_q;
    res_o.newest_sample = newest_sample_q;
  end

endmodule
`default_nettype wire

/* test/timestamp_history_interpolator_unit_checker.sv */
// ---------------------------------------------------------------------------
// Timestamp history interpolator checker
// Watches the command and result channels, keeps its own copy of the sample
// history, predicts each result and compares it field by field.
// ---------------------------------------------------------------------------
`default_nettype none
module timestamp_history_interpolator_unit_checker #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic                         busy_i,
  input  wire logic                         opcode_i,
  input  wire logic [thi_pkg::StampW-1:0]   stamp_i,
  input  wire logic [thi_pkg::SampleW-1:0]  sample_in_i,
  input  wire logic                         done_i,
  input  wire logic [thi_pkg::SampleW-1:0]  result_value_i,
  input  wire logic [thi_pkg::StatusW-1:0]  lookup_status_i,
  input  wire logic [thi_pkg::StampW-1:0]   oldest_stamp_i,
  input  wire logic [thi_pkg::StampW-1:0]   newest_stamp_i,
  input  wire logic [thi_pkg::SampleW-1:0]  newest_sample_i,
  output int                                mismatch_count_o,
  output int                                pending_count_o
);
  import thi_pkg::*;

  localparam int unsigned BufDepth = 16;

  logic [StampW-1:0]         hist_stamp [HISTORY_DEPTH];
  logic signed [SampleW-1:0] hist_sample [HISTORY_DEPTH];
  int unsigned               oldest_idx;
  // Predicted results in order; far more slots than the block can hold in flight.
  res_t                      exp_buf [BufDepth];
  int unsigned               wr_cnt = 0;
  int unsigned               rd_cnt = 0;

  assign pending_count_o = int'(wr_cnt - rd_cnt);

  // Applies one item to the shadow history and returns the result it gives.
  function automatic res_t apply_item(logic is_query, logic [StampW-1:0] target,
                                      logic signed [SampleW-1:0] sample);
    res_t r;
    int unsigned idx, pidx, newest;
    logic signed [SampleW:0] diff;
    logic [SampleW:0] mag;
    logic [ProdW-1:0] prod;
    logic [StampW-1:0] span;
    logic [QuoW-1:0] quo;
    r.value = '0;
    if (!is_query) begin
      hist_stamp[oldest_idx] = target;
      hist_sample[oldest_idx] = sample;
      oldest_idx = (oldest_idx + 1) % HISTORY_DEPTH;
      r.status = ST_INSERT_DONE;
    end else begin
      newest = (oldest_idx + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
      r.status = ST_AFTER;
      r.value = hist_sample[newest];
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        idx = (oldest_idx + k) % HISTORY_DEPTH;
        if (hist_stamp[idx] == target) begin
          r.value = hist_sample[idx];
          r.status = ST_EXACT;
          break;
        end
        if (hist_stamp[idx] > target) begin
          if (k == 0) begin
            r.value = hist_sample[idx];
            r.status = ST_BEFORE;
          end else begin
            pidx = (idx + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
            diff = $signed({hist_sample[idx][SampleW-1], hist_sample[idx]})
                 - $signed({hist_sample[pidx][SampleW-1], hist_sample[pidx]});
            mag = diff[SampleW] ? -diff : diff;
            prod = ProdW'(mag) * ProdW'(target - hist_stamp[pidx]);
            span = hist_stamp[idx] - hist_stamp[pidx];
            quo = QuoW'(prod / ProdW'(span));
            // The quotient never exceeds the difference, so the sum stays in range.
            if (diff[SampleW]) r.value = hist_sample[pidx] - SampleW'(quo);
            else r.value = hist_sample[pidx] + SampleW'(quo);
            r.status = ST_INTERP;
          end
          break;
        end
      end
    end
    newest = (oldest_idx + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
    r.oldest_stamp = hist_stamp[oldest_idx];
    r.newest_stamp = hist_stamp[newest];
    r.newest_sample = hist_sample[newest];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_stamp[i] = '0;
        hist_sample[i] = '0;
      end
      oldest_idx = 0;
      wr_cnt = 0;
      rd_cnt = 0;
      mismatch_count_o <= 0;
    end else begin
      if (done_i) begin
        if (wr_cnt == rd_cnt) begin
          if (mismatch_count_o < 10) $display("Unexpected result at %0t", $time);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = exp_buf[rd_cnt % BufDepth];
          rd_cnt = rd_cnt + 1;
          if (result_value_i !== want.value || lookup_status_i !== want.status ||
              oldest_stamp_i !== want.oldest_stamp ||
              newest_stamp_i !== want.newest_stamp ||
              newest_sample_i !== want.newest_sample) begin
            if (mismatch_count_o < 10)
              $display("Result differs: exp %h %0d %h %h %h got %h %0d %h %h %h",
                       want.value, want.status, want.oldest_stamp,
                       want.newest_stamp, want.newest_sample, result_value_i,
                       lookup_status_i, oldest_stamp_i, newest_stamp_i,
                       newest_sample_i);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        exp_buf[wr_cnt % BufDepth] = apply_item(opcode_i, stamp_i, sample_in_i);
        wr_cnt = wr_cnt + 1;
      end
    end
  end
endmodule
`default_nettype wire

/* test/timestamp_history_interpolator_unit_test.sv */
// ---------------------------------------------------------------------------
// Timestamp history interpolator testbench
// Drives inserts and queries into the block, with directed corner cases
// followed by random sequences, and reports the verdict of the checker.
// ---------------------------------------------------------------------------
`default_nettype none
module timestamp_history_interpolator_unit_test;
  import thi_pkg::*;

  localparam int unsigned Depth = 16;
  localparam int unsigned IdleLimit = 20000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                opcode = OpInsert;
  logic [StampW-1:0]   stamp = '0;
  logic [SampleW-1:0]  sample_in = '0;
  logic                busy, done;
  logic [SampleW-1:0]  result_value, newest_sample;
  logic [StatusW-1:0]  lookup_status;
  logic [StampW-1:0]   oldest_stamp, newest_stamp;
  int                  mismatch_count, pending_count;
  int unsigned         idle_cycles = 0;
  logic [StampW-1:0]   stamp_base;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  timestamp_history_interpolator_unit #(.HISTORY_DEPTH(Depth)) dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .opcode_i(opcode), .stamp_i(stamp), .sample_in_i(sample_in), .done_o(done),
    .result_value_o(result_value), .lookup_status_o(lookup_status),
    .oldest_stamp_o(oldest_stamp), .newest_stamp_o(newest_stamp),
    .newest_sample_o(newest_sample)
  );

  timestamp_history_interpolator_unit_checker #(.HISTORY_DEPTH(Depth)) checker_inst (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .opcode_i(opcode), .stamp_i(stamp), .sample_in_i(sample_in), .done_i(done),
    .result_value_i(result_value), .lookup_status_i(lookup_status),
    .oldest_stamp_i(oldest_stamp), .newest_stamp_i(newest_stamp),
    .newest_sample_i(newest_sample), .mismatch_count_o(mismatch_count),
    .pending_count_o(pending_count)
  );

  // The watchdog resets on every accepted item or result; a hang ends the run.
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Presents one item and holds it until the block accepts it. Start is then
  // lowered for a gap before the next item, so it is never lowered and raised
  // again in the same time step.
  task automatic issue_item(logic op, logic [StampW-1:0] ts, logic [SampleW-1:0] val);
    int unsigned gap;
    opcode <= op;
    stamp <= ts;
    sample_in <= val;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    opcode <= 1'($urandom_range(0, 1));
    stamp <= StampW'({$urandom, $urandom});
    sample_in <= $urandom;
    // Mostly short gaps, now and then a long one.
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
    repeat (gap + 1) @(posedge clk);
  endtask

  task automatic wait_until_drained();
    while (pending_count != 0) @(posedge clk);
  endtask

  // Random content for a sample: full range, small steps, or an extreme.
  function automatic logic [SampleW-1:0] random_sample();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      1: return SampleW'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned count;
    logic [StampW-1:0] ts;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fresh block: a zero target hits exactly, any other lands after the last entry.
    issue_item(OpQuery, '0, '0);
    issue_item(OpQuery, 48'hffff_ffff_ffff, 32'hffff_ffff);
    // Extreme values either side of a wide span, so the quotient uses every bit.
    issue_item(OpInsert, 48'h0000_0000_0010, 32'h8000_0000);
    issue_item(OpInsert, 48'hffff_ffff_fff0, 32'h7fff_ffff);
    issue_item(OpQuery, 48'h7fff_ffff_ffff, '0);
    issue_item(OpQuery, 48'hffff_ffff_ffef, '0);
    issue_item(OpQuery, 48'h0000_0000_0011, '0);
    issue_item(OpQuery, 48'hffff_ffff_ffff, '0);
    issue_item(OpQuery, 48'h0000_0000_0010, '0);
    // Falling slope, so the rounding toward zero acts on a negative step.
    issue_item(OpInsert, 48'hffff_ffff_fff5, 32'hffff_fffd);
    issue_item(OpQuery, 48'hffff_ffff_fff2, '0);
    // Fill the ring so that the oldest entry has a nonzero stamp.
    for (int i = 0; i < Depth; i++)
      issue_item(OpInsert, StampW'(100 + 10 * i), SampleW'(1000 * i));
    issue_item(OpQuery, 48'd5, '0);    // ahead of the oldest entry
    issue_item(OpQuery, 48'd137, '0);
    issue_item(OpQuery, 48'd1000, '0);
    wait_until_drained();

    // Random part: mostly ordered histories with queries into their range,
    // some unsorted ones and plain noise.
    count = 0;
    stamp_base = '0;
    while (count < 800) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          ts = stamp_base + $urandom_range(1, 50);
          stamp_base = ts;
          issue_item(OpInsert, ts, random_sample());
        end
        5, 6, 7: begin
          ts = stamp_base - $urandom_range(0, 16 * 30);
          if ($urandom_range(0, 7) == 0) ts = stamp_base + $urandom_range(0, 5);
          issue_item(OpQuery, ts, $urandom);
        end
        8: issue_item(1'($urandom_range(0, 1)), StampW'({$urandom, $urandom}), $urandom);
        default: begin
          // A jump far ahead or back, occasionally near the top of the range.
          stamp_base = ($urandom_range(0, 3) == 0) ? 48'hffff_ffff_f000
                                                   : StampW'({$urandom, $urandom});
          issue_item(OpInsert, stamp_base, random_sample());
        end
      endcase
      count++;
      if (count % 200 == 0) wait_until_drained();
    end

    wait_until_drained();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
